// ===== rtl/rolling_min_baseline_restore_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rolling-minimum baseline restoration block
// Shared concurrent assertion forms with clocking and reset disable built in.
// ----------------------------------------------------------------------------
`ifndef ROLLING_MIN_BASELINE_RESTORE_MACROS_SVH
`define ROLLING_MIN_BASELINE_RESTORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define RMBR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define RMBR_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rmbr_pkg.sv =====
// ----------------------------------------------------------------------------
// Rolling-minimum baseline restoration package
// Shared constants, register codes and control types.
// ----------------------------------------------------------------------------
package rmbr_pkg;

  localparam int WINDOW_MAX_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int WIN_LEN_W  = 9;
  localparam int WIN_LEN_RESET = 64;

  // Number of taps folded together in the first level of the tap selector.
  localparam int TAP_GROUP = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH    = 1'b0,
    REG_UNBOUNDED_WINDOW = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic shift_en;
    logic restart;
  } cell_ctrl_t;

endpackage

// ===== rtl/rmbr_if.sv =====
// ----------------------------------------------------------------------------
// Rolling-minimum baseline restoration channel interfaces
// Valid/ready channels for incoming samples and restored results.
// ----------------------------------------------------------------------------
interface rmbr_in_if #(
  parameter int SAMPLE_BITS = rmbr_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          record_start;

  modport source (output valid, output sample, output record_start, input ready);
  modport sink (input valid, input sample, input record_start, output ready);
endinterface

interface rmbr_out_if #(
  parameter int SAMPLE_BITS = rmbr_pkg::SAMPLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] restored;

  modport source (output valid, output restored, input ready);
  modport sink (input valid, input restored, output ready);
endinterface

// ===== rtl/rmbr_cell.sv =====
// ----------------------------------------------------------------------------
// Rolling-minimum cell
// Holds the minimum of the last (index + 1) samples of the record and hands
// it to the next cell on every accepted transaction.
// ----------------------------------------------------------------------------
module rmbr_cell #(
  parameter int SAMPLE_BITS = rmbr_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W       = 8,
  parameter int CELL_IDX    = 0
) (
  input  logic                          clk_i,
  input  rmbr_pkg::cell_ctrl_t          ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] left_i,
  input  logic        [IDX_W-1:0]       win_last_i,
  output logic signed [SAMPLE_BITS-1:0] value_o,
  output logic        [SAMPLE_BITS-1:0] tap_o
);

  logic signed [SAMPLE_BITS-1:0] value_q;
  logic signed [SAMPLE_BITS-1:0] value_d;
  logic                          selected;

  always_comb begin
    if (ctrl_i.restart || (sample_i < left_i)) begin
      value_d = sample_i;
    end else begin
      value_d = left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en) begin
      value_q <= value_d;
    end
  end

  assign selected = (win_last_i == IDX_W'(CELL_IDX));
  assign value_o  = value_q;
  assign tap_o    = selected ? value_q : '0;

endmodule

// ===== rtl/rmbr_tap_sel.sv =====
// ----------------------------------------------------------------------------
// Rolling-minimum tap selector
// Two-level registered OR tree that picks the one enabled cell tap.
// ----------------------------------------------------------------------------
module rmbr_tap_sel #(
  parameter int WINDOW_MAX  = rmbr_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = rmbr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  adv_i,
  input  logic [WINDOW_MAX-1:0][SAMPLE_BITS-1:0] taps_i,
  output logic [SAMPLE_BITS-1:0]                min_o
);

  localparam int G  = rmbr_pkg::TAP_GROUP;
  localparam int NG = (WINDOW_MAX + G - 1) / G;

  logic [NG*G-1:0][SAMPLE_BITS-1:0] taps_pad;
  logic [NG-1:0][SAMPLE_BITS-1:0]   group_d;
  logic [NG-1:0][SAMPLE_BITS-1:0]   group_q;
  logic [SAMPLE_BITS-1:0]           min_d;
  logic [SAMPLE_BITS-1:0]           min_q;

  assign taps_pad = (NG*G*SAMPLE_BITS)'(taps_i);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      group_d[g] = '0;
      for (int e = 0; e < G; e++) begin
        group_d[g] = group_d[g] | taps_pad[g*G+e];
      end
    end
  end

  always_comb begin
    min_d = '0;
    for (int g = 0; g < NG; g++) begin
      min_d = min_d | group_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      group_q <= group_d;
      min_q   <= min_d;
    end
  end

  assign min_o = min_q;

endmodule

// ===== rtl/rolling_min_baseline_restore.sv =====
// ----------------------------------------------------------------------------
// Rolling-minimum baseline restoration
// Subtracts the minimum of the preceding samples of a record from each sample.
// ----------------------------------------------------------------------------
// One sample is accepted per clock while the result side keeps up, and each
// result passes through the s1, s2 and restored registers. A row of WINDOW_MAX
// cells keeps, in cell j, the minimum of the last j+1 samples; every sample
// updates the whole row at once, and a two-level registered OR tree
// reads the cell at window_length-1. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module rolling_min_baseline_restore #(
  parameter int WINDOW_MAX  = rmbr_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = rmbr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rmbr_in_if.sink                         sample_i,
  rmbr_out_if.source                      result_o,
  input  logic                            cfg_we_i,
  input  logic [rmbr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rmbr_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int WIN_LAST_RST =
    (rmbr_pkg::WIN_LEN_RESET > WINDOW_MAX) ? WINDOW_MAX - 1 : rmbr_pkg::WIN_LEN_RESET - 1;

  logic [IDX_W-1:0] win_last_q, win_last_d;
  logic             unbounded_q, unbounded_d;
  logic [31:0]      wl_ext;

  logic adv;
  logic acc;
  logic nonempty_q;
  logic restart;

  logic signed [SAMPLE_BITS-1:0] rmin_q;

  rmbr_pkg::cell_ctrl_t cell_ctrl;

  logic signed [WINDOW_MAX-1:0][SAMPLE_BITS-1:0] cell_val;
  logic        [WINDOW_MAX-1:0][SAMPLE_BITS-1:0] cell_tap;
  logic        [SAMPLE_BITS-1:0]                 win_min;

  logic                          v1_q, v2_q;
  logic signed [SAMPLE_BITS-1:0] s1_q, s2_q;
  logic signed [SAMPLE_BITS-1:0] rmin1_q, rmin2_q;
  logic                          first1_q, first2_q;
  logic                          unb1_q, unb2_q;

  logic                        out_valid_q;
  logic signed [SAMPLE_BITS:0] restored_q, restored_d;
  logic        [SAMPLE_BITS-1:0] base;

  // Configuration registers.
  assign wl_ext = 32'(cfg_wdata_i[rmbr_pkg::WIN_LEN_W-1:0]);

  always_comb begin
    win_last_d  = win_last_q;
    unbounded_d = unbounded_q;
    if (cfg_we_i) begin
      unique case (rmbr_pkg::cfg_reg_e'(cfg_idx_i))
        rmbr_pkg::REG_WINDOW_LENGTH: begin
          priority if (wl_ext == 32'd0) begin
            win_last_d = '0;
          end else if (wl_ext > 32'(WINDOW_MAX)) begin
            win_last_d = IDX_W'(WINDOW_MAX - 1);
          end else begin
            win_last_d = IDX_W'(wl_ext - 32'd1);
          end
        end
        rmbr_pkg::REG_UNBOUNDED_WINDOW: begin
          unbounded_d = cfg_wdata_i[0];
        end
        default: begin
          win_last_d = win_last_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_last_q  <= IDX_W'(WIN_LAST_RST);
      unbounded_q <= 1'b0;
    end else begin
      win_last_q  <= win_last_d;
      unbounded_q <= unbounded_d;
    end
  end

  // Handshake and record tracking.
  assign adv            = !out_valid_q || result_o.ready;
  assign sample_i.ready = adv;
  assign acc            = sample_i.valid && adv;
  assign restart        = !nonempty_q || sample_i.record_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q <= 1'b0;
    end else if (acc) begin
      nonempty_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && (restart || (sample_i.sample < rmin_q))) begin
      rmin_q <= sample_i.sample;
    end
  end

  // Row of minimum cells.
  assign cell_ctrl.shift_en = acc;
  assign cell_ctrl.restart  = restart;

  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] left;
    if (j == 0) begin : g_head
      assign left = sample_i.sample;
    end else begin : g_body
      assign left = cell_val[j-1];
    end
    rmbr_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_W       (IDX_W),
      .CELL_IDX    (j)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .sample_i   (sample_i.sample),
      .left_i     (left),
      .win_last_i (win_last_q),
      .value_o    (cell_val[j]),
      .tap_o      (cell_tap[j])
    );
  end

  rmbr_tap_sel #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_tap_sel (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .taps_i (cell_tap),
    .min_o  (win_min)
  );

  // Pipeline alongside the tap selector.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= acc;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q       <= sample_i.sample;
      rmin1_q    <= rmin_q;
      first1_q   <= restart;
      unb1_q     <= unbounded_q;
      s2_q       <= s1_q;
      rmin2_q    <= rmin1_q;
      first2_q   <= first1_q;
      unb2_q     <= unb1_q;
      restored_q <= restored_d;
    end
  end

  always_comb begin
    base = unb2_q ? rmin2_q : win_min;
    priority if (first2_q && unb2_q) begin
      restored_d = {s2_q[SAMPLE_BITS-1], s2_q};
    end else if (first2_q) begin
      restored_d = '0;
    end else begin
      restored_d = {s2_q[SAMPLE_BITS-1], s2_q} - {base[SAMPLE_BITS-1], base};
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.restored = restored_q;

endmodule

// ===== rtl/rmbr_checker.sv =====
// ----------------------------------------------------------------------------
// Rolling-minimum baseline restoration checker
// Port-level assertions, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
`include "rolling_min_baseline_restore_macros.svh"

module rmbr_checker #(
  parameter int SAMPLE_BITS = rmbr_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS:0]   restored_i
);

  localparam logic [SAMPLE_BITS:0] MOST_NEG = {1'b1, {SAMPLE_BITS{1'b0}}};

  `RMBR_ASSERT_IMP(a_ready_only_stalled, clk_i, rst_ni, !in_ready_i,
                   out_valid_i && !out_ready_i, "input stalled without a blocked result")
  `RMBR_ASSERT_IMP(a_restored_range, clk_i, rst_ni, out_valid_i,
                   restored_i != MOST_NEG, "restored value out of range")
  `RMBR_ASSERT_NXT(a_result_held, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(restored_i), "stalled result changed")

endmodule

bind rolling_min_baseline_restore rmbr_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_rmbr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .restored_i  (result_o.restored)
);
